// ----- rtl/core/qss_pkg.sv -----
`default_nettype none

package qss_pkg;

  localparam int DATA_W        = 32;
  localparam int INDEX_W       = 7;
  localparam int FILL_W        = 8;
  localparam int CMD_W         = 2;
  localparam int STATUS_W      = 2;
  localparam int DEPTH_DEFAULT = 128;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    status_t                  status;
    logic [FILL_W-1:0]        fill_count;
  } rsp_t;

  typedef struct packed {
    logic write;
    logic shift;
  } chain_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/qss_ifs.sv -----
`default_nettype none

interface qss_req_if
  import qss_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [DATA_W-1:0]  value;
  logic [INDEX_W-1:0]        index;

  modport source (output valid, command, value, index, input ready);
  modport sink   (input valid, command, value, index, output ready);
endinterface

interface qss_rsp_if
  import qss_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  data;
  logic [STATUS_W-1:0]       status;
  logic [FILL_W-1:0]         fill_count;

  modport source (output valid, data, status, fill_count, input ready);
  modport sink   (input valid, data, status, fill_count, output ready);
endinterface

interface qss_cfg_if;
  logic valid;
  logic ready;
  logic order_mode;

  modport source (output valid, order_mode, input ready);
  modport sink   (input valid, order_mode, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/qss_cell.sv -----
`default_nettype none

module qss_cell
  import qss_pkg::*;
#(
  parameter int PW  = 7,
  parameter int POS = 0
) (
  input  wire logic                     clk,
  input  wire chain_ctrl_t              ctrl,
  input  wire logic [PW-1:0]            wr_pos,
  input  wire logic [PW-1:0]            rd_pos,
  input  wire logic signed [DATA_W-1:0] push_word,
  input  wire logic signed [DATA_W-1:0] nbr_word,
  input  wire logic signed [DATA_W-1:0] bus_in,
  output logic signed [DATA_W-1:0]      word,
  output logic signed [DATA_W-1:0]      bus
);

  localparam logic [PW-1:0] ME = PW'(POS);

  always_ff @(posedge clk) begin
    if (ctrl.write && (wr_pos == ME)) begin
      word <= push_word;
    end else if (ctrl.shift) begin
      word <= nbr_word;
    end
    // read bus moves one cell toward the head each cycle
    bus <= (rd_pos == ME) ? word : bus_in;
  end

endmodule

`default_nettype wire

// ----- rtl/core/qss_chain.sv -----
`default_nettype none

module qss_chain
  import qss_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int PW    = $clog2(DEPTH)
) (
  input  wire logic                     clk,
  input  wire chain_ctrl_t              ctrl,
  input  wire logic [PW-1:0]            wr_pos,
  input  wire logic [PW-1:0]            rd_pos,
  input  wire logic signed [DATA_W-1:0] push_word,
  output logic signed [DATA_W-1:0]      head_word,
  output logic signed [DATA_W-1:0]      rd_word
);

  logic signed [DATA_W-1:0] words [DEPTH+1];
  logic signed [DATA_W-1:0] buses [DEPTH+1];

  assign words[DEPTH] = '0;
  assign buses[DEPTH] = '0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    qss_cell #(
      .PW  (PW),
      .POS (k)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .wr_pos    (wr_pos),
      .rd_pos    (rd_pos),
      .push_word (push_word),
      .nbr_word  (words[k+1]),
      .bus_in    (buses[k+1]),
      .word      (words[k]),
      .bus       (buses[k])
    );
  end

  assign head_word = words[0];
  assign rd_word   = buses[0];

endmodule

`default_nettype wire

// ----- rtl/core/qss_out_buf.sv -----
`default_nettype none

module qss_out_buf
  import qss_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   wr_en,
  input  wire rsp_t   wr_word,
  output logic        room,
  qss_rsp_if.source   rsp
);

  rsp_t       slot0;
  rsp_t       slot1;
  logic [1:0] cnt;
  logic       pop;

  assign pop            = rsp.valid && rsp.ready;
  assign room           = (cnt != 2'd2);
  assign rsp.valid      = (cnt != 2'd0);
  assign rsp.data       = slot0.data;
  assign rsp.status     = slot0.status;
  assign rsp.fill_count = slot0.fill_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({wr_en, pop})
        2'b10: begin
          if (cnt == 2'd0) begin
            slot0 <= wr_word;
          end else begin
            slot1 <= wr_word;
          end
          cnt <= cnt + 2'd1;
        end
        2'b01: begin
          slot0 <= slot1;
          cnt   <= cnt - 2'd1;
        end
        2'b11: begin
          if (cnt == 2'd1) begin
            slot0 <= wr_word;
          end else begin
            slot0 <= slot1;
            slot1 <= wr_word;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/queue_stack_store.sv -----
// Bounded store of DEPTH signed 32-bit words, run as a queue (order_mode 0,
// pop oldest) or a stack (order_mode 1, pop newest); a read returns the word
// at an index counted from the oldest. Words sit in a row of cells in age
// order, oldest in cell 0: a push writes the cell at the fill count and a
// queue pop takes cell 0 while every cell loads its neighbor, so push, queue
// pop and every refused command write their result into the result buffer
// in the cycle they are accepted. A stack pop or read of entry n is carried
// to the head over a registered read bus that moves one cell per cycle
// (n = fill - 1 for a stack pop). One command is worked on at a time;
// a two-word result buffer lets the next command in while results wait.
// Write order_mode only while idle.
`default_nettype none

module queue_stack_store
  import qss_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  qss_req_if.sink   req,
  qss_rsp_if.source rsp,
  qss_cfg_if.sink   cfg
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = (CW > INDEX_W) ? CW : INDEX_W;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t                   state;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [CW-1:0]            count_dec;
  logic [CW-1:0]            walk_cnt;
  logic [PW-1:0]            rd_pos;
  logic [PW-1:0]            target;
  logic [FILL_W-1:0]        hold_fill;
  logic                     stack_mode;
  logic                     acc;
  logic                     full;
  logic                     empty;
  logic                     in_range;
  logic                     imm_done;
  logic                     go_walk;
  logic                     walk_done;
  logic signed [DATA_W-1:0] res_data;
  status_t                  res_status;
  chain_ctrl_t              ctrl;
  logic signed [DATA_W-1:0] head_word;
  logic signed [DATA_W-1:0] rd_word;
  logic                     buf_wr;
  logic                     buf_room;
  rsp_t                     buf_word;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE) && buf_room;
  assign acc       = req.valid && req.ready;

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign count_dec = count - CW'(1);
  assign in_range  = WW'(req.index) < WW'(count);
  assign walk_done = (state == S_WALK) && (walk_cnt == '0);

  always_comb begin
    ctrl       = '0;
    count_next = count;
    imm_done   = 1'b0;
    go_walk    = 1'b0;
    target     = '0;
    res_data   = '0;
    res_status = ST_OK;
    if (acc) begin
      case (cmd_t'(req.command))
        CMD_PUSH: begin
          imm_done = 1'b1;
          if (full) begin
            res_status = ST_FULL;
          end else begin
            ctrl.write = 1'b1;
            count_next = count + CW'(1);
          end
        end
        CMD_POP: begin
          if (empty) begin
            imm_done   = 1'b1;
            res_status = ST_EMPTY;
          end else if (stack_mode) begin
            go_walk    = 1'b1;
            count_next = count_dec;
            target     = count_dec[PW-1:0];
          end else begin
            imm_done   = 1'b1;
            res_data   = head_word;
            ctrl.shift = 1'b1;
            count_next = count_dec;
          end
        end
        CMD_READ: begin
          if (!in_range) begin
            imm_done   = 1'b1;
            res_status = ST_RANGE;
          end else begin
            go_walk = 1'b1;
            target  = PW'(req.index);
          end
        end
        default: begin
          imm_done = 1'b1;
        end
      endcase
    end
  end

  assign buf_wr = imm_done || walk_done;

  always_comb begin
    if (imm_done) begin
      buf_word.data       = res_data;
      buf_word.status     = res_status;
      buf_word.fill_count = FILL_W'(count_next);
    end else begin
      buf_word.data       = rd_word;
      buf_word.status     = ST_OK;
      buf_word.fill_count = hold_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      stack_mode <= 1'b0;
      walk_cnt   <= '0;
    end else begin
      if (cfg.valid) begin
        stack_mode <= cfg.order_mode;
      end
      count <= count_next;
      case (state)
        S_IDLE: begin
          if (go_walk) begin
            state     <= S_WALK;
            rd_pos    <= target;
            walk_cnt  <= CW'(target) + CW'(1);
            hold_fill <= FILL_W'(count_next);
          end
        end
        S_WALK: begin
          if (walk_cnt == '0) begin
            state <= S_IDLE;
          end else begin
            walk_cnt <= walk_cnt - CW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  qss_chain #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .wr_pos    (count[PW-1:0]),
    .rd_pos    (rd_pos),
    .push_word (req.value),
    .head_word (head_word),
    .rd_word   (rd_word)
  );

  qss_out_buf u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (buf_wr),
    .wr_word (buf_word),
    .room    (buf_room),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire
